// File: rtl/assert_macros.svh
// Assertion shorthands used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mrdc_pkg.sv
package mrdc_pkg;

	localparam logic [6:0] FULL_SPEED      = 7'd100;
	localparam logic [6:0] RAMP_STEP_RESET = 7'd5;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_UP   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_DOWN = 1'b1;

	localparam logic [2:0] DIR_STOP    = 3'd0;
	localparam logic [2:0] DIR_FORWARD = 3'd1;
	localparam logic [2:0] DIR_REVERSE = 3'd2;
	localparam logic [2:0] DIR_LEFT    = 3'd3;
	localparam logic [2:0] DIR_RIGHT   = 3'd4;

	localparam logic [3:0] BRIDGE_STOP    = 4'b0000;
	localparam logic [3:0] BRIDGE_FORWARD = 4'b1010;
	localparam logic [3:0] BRIDGE_REVERSE = 4'b0101;
	localparam logic [3:0] BRIDGE_LEFT    = 4'b0110;
	localparam logic [3:0] BRIDGE_RIGHT   = 4'b1001;

	typedef enum logic [2:0] {
		OP_CONTROL_TICK = 3'd0,
		OP_SET_TARGET   = 3'd1,
		OP_GO           = 3'd2,
		OP_TIMER_TICK   = 3'd3,
		OP_FAULT        = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  speed_value;
		logic [2:0]  direction_value;
		logic [15:0] run_ticks;
	} in_item_t;

	typedef struct packed {
		logic [6:0] speed;
		logic [6:0] pwm_off_percent;
		logic [2:0] direction;
		logic [3:0] bridge_pattern;
		logic       running;
		logic       ramp_busy;
		logic       run_timer_active;
		logic       fault_seen;
	} out_item_t;

	typedef struct packed {
		logic [6:0]  speed_now;
		logic [6:0]  speed_target;
		logic [2:0]  direction_now;
		logic [2:0]  direction_target;
		logic [3:0]  bridge_bits;
		logic        running_flag;
		logic        active_flag;
		logic        timer_on;
		logic [15:0] tick_count;
		logic [15:0] run_length;
		logic        fault_latch;
	} ctl_state_t;

	function automatic logic [6:0] clamp_speed(input logic [7:0] v);
		return (v > {1'b0, FULL_SPEED}) ? FULL_SPEED : v[6:0];
	endfunction

	function automatic logic [2:0] norm_dir(input logic [2:0] d);
		return (d > DIR_RIGHT) ? DIR_STOP : d;
	endfunction

	function automatic logic [3:0] bridge_for(input logic [2:0] d);
		logic [3:0] b;
		case (d)
			DIR_FORWARD: b = BRIDGE_FORWARD;
			DIR_REVERSE: b = BRIDGE_REVERSE;
			DIR_LEFT:    b = BRIDGE_LEFT;
			DIR_RIGHT:   b = BRIDGE_RIGHT;
			default:     b = BRIDGE_STOP;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/mrdc_next.sv
module mrdc_next (
	input  mrdc_pkg::ctl_state_t st,
	input  mrdc_pkg::in_item_t   item,
	input  logic [6:0]           up_step,
	input  logic [6:0]           down_step,
	output mrdc_pkg::ctl_state_t nxt,
	output mrdc_pkg::out_item_t  result
);

	logic [7:0]  up_sum;
	logic [6:0]  down_val;
	logic [6:0]  ramp;
	logic        ramp_up;
	logic [15:0] tick_inc;
	logic [2:0]  go_dir;

	always_comb begin
		nxt      = st;
		up_sum   = {1'b0, st.speed_now} + {1'b0, up_step};
		down_val = (st.speed_now < down_step) ? 7'd0 : (st.speed_now - down_step);
		ramp_up  = st.speed_target > st.speed_now;
		tick_inc = st.tick_count + 16'd1;
		go_dir   = mrdc_pkg::norm_dir(item.direction_value);
		if (ramp_up) begin
			ramp = (up_sum > {1'b0, st.speed_target}) ? st.speed_target : up_sum[6:0];
		end else begin
			ramp = (down_val < st.speed_target) ? st.speed_target : down_val;
		end

		case (item.operation)
			mrdc_pkg::OP_CONTROL_TICK: begin
				if (st.direction_now == st.direction_target &&
					st.speed_now == st.speed_target) begin
					nxt.active_flag = 1'b0;
				end else begin
					nxt.active_flag = 1'b1;
					nxt.speed_now   = ramp;
					if (!ramp_up && ramp == 7'd0) begin
						nxt.direction_now = mrdc_pkg::DIR_STOP;
						nxt.bridge_bits   = mrdc_pkg::BRIDGE_STOP;
						nxt.running_flag  = 1'b0;
					end
					if (nxt.direction_now == mrdc_pkg::DIR_STOP) begin
						nxt.direction_now = st.direction_target;
						nxt.bridge_bits   = mrdc_pkg::bridge_for(st.direction_target);
						if (st.direction_target == mrdc_pkg::DIR_STOP) begin
							nxt.speed_now    = 7'd0;
							nxt.running_flag = 1'b0;
						end else begin
							nxt.running_flag = 1'b1;
						end
					end else if (nxt.direction_now != st.direction_target) begin
						nxt.speed_target = 7'd0;
					end
				end
			end
			mrdc_pkg::OP_SET_TARGET: begin
				nxt.speed_target     = mrdc_pkg::clamp_speed(item.speed_value);
				nxt.direction_target = go_dir;
			end
			mrdc_pkg::OP_GO: begin
				nxt.direction_now = go_dir;
				nxt.bridge_bits   = mrdc_pkg::bridge_for(go_dir);
				if (go_dir == mrdc_pkg::DIR_STOP) begin
					nxt.speed_now    = 7'd0;
					nxt.running_flag = 1'b0;
				end else begin
					nxt.speed_now    = mrdc_pkg::clamp_speed(item.speed_value);
					nxt.running_flag = 1'b1;
				end
				nxt.run_length = item.run_ticks;
				nxt.tick_count = 16'd0;
				nxt.timer_on   = item.run_ticks != 16'd0;
			end
			mrdc_pkg::OP_TIMER_TICK: begin
				if (st.timer_on) begin
					if (tick_inc == st.run_length) begin
						nxt.tick_count    = 16'd0;
						nxt.timer_on      = 1'b0;
						nxt.speed_now     = 7'd0;
						nxt.direction_now = mrdc_pkg::DIR_STOP;
						nxt.bridge_bits   = mrdc_pkg::BRIDGE_STOP;
						nxt.running_flag  = 1'b0;
					end else begin
						nxt.tick_count = tick_inc;
					end
				end
			end
			mrdc_pkg::OP_FAULT: begin
				nxt.speed_now     = 7'd0;
				nxt.direction_now = mrdc_pkg::DIR_STOP;
				nxt.bridge_bits   = mrdc_pkg::BRIDGE_STOP;
				nxt.running_flag  = 1'b0;
				nxt.fault_latch   = 1'b1;
			end
			default: begin
				nxt = st;
			end
		endcase
	end

	always_comb begin
		result.speed            = nxt.speed_now;
		result.pwm_off_percent  = mrdc_pkg::FULL_SPEED - nxt.speed_now;
		result.direction        = nxt.direction_now;
		result.bridge_pattern   = nxt.bridge_bits;
		result.running          = nxt.running_flag;
		result.ramp_busy        = nxt.active_flag;
		result.run_timer_active = nxt.timer_on;
		result.fault_seen       = nxt.fault_latch;
	end

endmodule

// File: rtl/motor_ramp_direction_controller.sv
// Motor speed ramp and direction controller.
// Each transaction is held in the input register and its result in the output register.
// Throughput: one transaction per cycle unless out_stall holds back a waiting result; the input
// register, one pass of next-state logic and the output register set that rate.
// Reset: arst_n clears all motor state and empties both pipeline stages; ramp steps return to 5.
module motor_ramp_direction_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mrdc_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mrdc_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [mrdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mrdc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	mrdc_pkg::in_item_t   item_s1;
	logic                 valid_s1;
	mrdc_pkg::ctl_state_t state_q;
	mrdc_pkg::ctl_state_t state_next;
	mrdc_pkg::out_item_t  result;
	mrdc_pkg::out_item_t  out_data_q;
	logic                 out_valid_q;
	logic [6:0]           up_step_q;
	logic [6:0]           down_step_q;
	logic                 out_free;
	logic                 s1_free;
	logic                 advance;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign advance  = valid_s1 && out_free;
	assign in_stall = !s1_free;

	mrdc_next u_next (
		.st        (state_q),
		.item      (item_s1),
		.up_step   (up_step_q),
		.down_step (down_step_q),
		.nxt       (state_next),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
			up_step_q   <= mrdc_pkg::RAMP_STEP_RESET;
			down_step_q <= mrdc_pkg::RAMP_STEP_RESET;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q <= state_next;
			end
			if (cfg_we) begin
				case (cfg_index)
					mrdc_pkg::CFG_RAMP_UP:   up_step_q   <= cfg_wdata;
					mrdc_pkg::CFG_RAMP_DOWN: down_step_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/mrdc_checker.sv
`include "assert_macros.svh"

module mrdc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input mrdc_pkg::in_item_t                in_data,
	input logic                              out_valid,
	input logic                              out_stall,
	input mrdc_pkg::out_item_t               out_data,
	input logic                              cfg_we,
	input logic [mrdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input logic [mrdc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic out_take;
	logic inputs_known;

	assign out_take     = out_valid && !out_stall;
	assign inputs_known = (!in_valid || !$isunknown(in_data)) &&
		(!cfg_we || (!$isunknown(cfg_index) && !$isunknown(cfg_wdata)));

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled result changed")
	`ASSERT_IMPLY(a_no_stall_back, clk, arst_n, !out_stall, !in_stall,
		"input stalled while output is free")
	`ASSERT_NEXT(a_fault_sticky, clk, arst_n, out_take && out_data.fault_seen,
		!out_valid || out_data.fault_seen, "fault flag cleared without reset")
	`ASSERT_IMPLY(a_stop_consistent, clk, arst_n, out_valid && !out_data.running,
		out_data.bridge_pattern == mrdc_pkg::BRIDGE_STOP && out_data.speed == 7'd0,
		"stopped motors still driven")
	`ASSERT_IMPLY(a_inputs_known, clk, arst_n, in_valid || cfg_we, inputs_known,
		"offered transaction carries unknown bits")

endmodule

bind motor_ramp_direction_controller mrdc_checker u_mrdc_checker (.*);
